### rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros shared by the circular deque RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, idle during reset.
`define CDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checked at every rising clock edge, also while reset is high.
`define CDQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/core/cdq_pkg.sv
// cdq_pkg: types and constants of the circular deque.
// No dependencies; used by cdq_cell and circular_deque.
`default_nettype none

package cdq_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 3;
   localparam int CSR_W     = 5;
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W     = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   localparam logic [CSR_W-1:0] CAPACITY_RESET = CSR_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_QUERY      = 3'd4
   } cdq_cmd_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_REAR,
      OP_POP_FRONT,
      OP_POP_REAR
   } cdq_op_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
   } cdq_req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } cdq_rsp_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] data;
   } cdq_link_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cdq_op_type        op;
      logic [DATA_W-1:0] value;
   } cdq_ctl_type;

endpackage

`default_nettype wire

### rtl/core/cdq_cell.sv
// cdq_cell: one slot of the deque row, holding a value and an occupied bit.
// Depends on cdq_pkg.
`default_nettype none

module cdq_cell
   import cdq_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  cdq_ctl_type  ctl,
   input  cdq_link_type prev,
   input  cdq_link_type next,
   output cdq_link_type slot_out,
   output logic         is_rear
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (ctl.op)
         OP_PUSH_FRONT: begin
            valid_in = prev.valid;
            data_in  = prev.data;
         end
         OP_PUSH_REAR: begin
            // first free slot takes the value
            if (!valid_ff && prev.valid) begin
               valid_in = 1'b1;
               data_in  = ctl.value;
            end
         end
         OP_POP_FRONT: begin
            valid_in = next.valid;
            data_in  = next.data;
         end
         OP_POP_REAR: begin
            if (valid_ff && !next.valid) begin
               valid_in = 1'b0;
            end
         end
         OP_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign slot_out.valid = valid_ff;
   assign slot_out.data  = data_ff;
   assign is_rear        = valid_ff && !next.valid;

endmodule

`default_nettype wire

### rtl/core/circular_deque.sv
// circular_deque: top level of the double-ended queue of 32-bit values.
// Depends on cdq_pkg, cdq_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A double-ended queue of up to MAX_DEPTH signed 32-bit values. Each req beat
// carries a command (push front, push rear, pop front, pop rear, query) and
// each produces exactly one rsp beat with the ok flag, the front and rear
// values (all ones when empty) and the empty/full flags as they stand after
// the command. A push into a full deque or a pop from an empty one returns
// ok=0 and changes nothing; unknown command codes act as a query with ok=0.
// The values live in a row of cells ordered front to rear: a front push or
// pop shifts the whole row by one cell, all cells at once, a rear push fills
// the first free cell and a rear pop clears the last occupied one. Timing:
// a req beat updates the row at its accept edge and sets pend_ff; the
// response is captured from the row into the output register as soon as
// that register is free, and a new req beat can be taken on the capture
// edge, so the block sustains one beat per cycle while rsp_ready stays
// high; rsp_valid rises with that capture. A beat may be taken while an
// earlier response still waits in the output register; only a second
// stalled response holds off req_ready. The capacity register
// (csr_wdata) limits how many values may be held; values above MAX_DEPTH
// act as MAX_DEPTH, zero refuses every push. It resets to 16 and should be
// written only while no beat is in flight. No clearing pass after reset.

module circular_deque
   import cdq_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  cdq_req_type       req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output cdq_rsp_type       rsp_data,
   input  wire               csr_we,
   input  wire [CSR_W-1:0]   csr_wdata
);

   // ---------------------------------------------------------------- state
   logic [CSR_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_ff, pend_in;       // row updated, response not yet in the output register
   logic             pend_ok_ff, pend_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cdq_rsp_type      rsp_data_ff, rsp_data_in;

   logic             req_fire, out_free, pend_move;
   logic             full, empty, ok;
   logic [CMP_W-1:0] eff_cap;
   cdq_ctl_type      ctl;

   // ---------------------------------------------------------------- flags
   always_comb begin
      eff_cap = (CMP_W'(capacity_ff) > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH)
                                                          : CMP_W'(capacity_ff);
   end

   assign full  = CMP_W'(count_ff) >= eff_cap;
   assign empty = (count_ff == '0);

   // ------------------------------------------------------------ handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pend_move = pend_ff && out_free;
   assign req_ready = !pend_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   // ------------------------------------------------------- command decode
   always_comb begin
      ctl.op    = OP_HOLD;
      ctl.value = req_data.value;
      ok        = 1'b0;
      unique case (req_data.cmd)
         CMD_PUSH_FRONT: begin
            if (!full) begin
               ctl.op = OP_PUSH_FRONT;
               ok     = 1'b1;
            end
         end
         CMD_PUSH_REAR: begin
            if (!full) begin
               ctl.op = OP_PUSH_REAR;
               ok     = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (!empty) begin
               ctl.op = OP_POP_FRONT;
               ok     = 1'b1;
            end
         end
         CMD_POP_REAR: begin
            if (!empty) begin
               ctl.op = OP_POP_REAR;
               ok     = 1'b1;
            end
         end
         CMD_QUERY: ok = 1'b1;
         default: ok = 1'b0;  // unused codes: query with ok low
      endcase
      if (!req_fire) begin
         ctl.op = OP_HOLD;
      end
   end

   // ------------------------------------------------------------ cell row
   cdq_link_type           cell_q [MAX_DEPTH];
   cdq_link_type           head_link;
   cdq_link_type           tail_link;
   logic [MAX_DEPTH-1:0]   rear_hit;
   logic [MAX_DEPTH-1:0]   valid_vec;

   // front neighbor of cell 0 is the incoming value; past the last cell is nothing
   assign head_link.valid = 1'b1;
   assign head_link.data  = ctl.value;
   assign tail_link       = '0;

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      cdq_link_type prev_link, next_link;
      if (i == 0) begin : g_first
         assign prev_link = head_link;
      end else begin : g_mid
         assign prev_link = cell_q[i-1];
      end
      if (i == MAX_DEPTH - 1) begin : g_last
         assign next_link = tail_link;
      end else begin : g_inner
         assign next_link = cell_q[i+1];
      end

      cdq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .prev     (prev_link),
         .next     (next_link),
         .slot_out (cell_q[i]),
         .is_rear  (rear_hit[i])
      );

      assign valid_vec[i] = cell_q[i].valid;
   end

   // rear value: at most one cell flags itself as the last occupied one
   logic [DATA_W-1:0] rear_or;
   always_comb begin
      rear_or = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         rear_or = rear_or | (rear_hit[i] ? cell_q[i].data : '0);
      end
   end

   // --------------------------------------------------------- next values
   always_comb begin
      count_in = count_ff;
      unique case (ctl.op)
         OP_PUSH_FRONT, OP_PUSH_REAR: count_in = count_ff + CNT_W'(1);
         OP_POP_FRONT, OP_POP_REAR:   count_in = count_ff - CNT_W'(1);
         OP_HOLD:                     count_in = count_ff;
         default:                     count_in = count_ff;
      endcase
   end

   assign capacity_in = csr_we ? csr_wdata : capacity_ff;

   always_comb begin
      pend_in    = pend_ff;
      pend_ok_in = pend_ok_ff;
      priority if (req_fire) begin
         pend_in    = 1'b1;
         pend_ok_in = ok;
      end else if (pend_move) begin
         pend_in = 1'b0;
      end
   end

   // response snapshot: the row and count already hold the post-command state
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (pend_move) begin
         rsp_data_in.ok          = pend_ok_ff;
         rsp_data_in.front_value = empty ? '1 : cell_q[0].data;
         rsp_data_in.rear_value  = empty ? '1 : rear_or;
         rsp_data_in.is_empty    = empty;
         rsp_data_in.is_full     = full;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         pend_ok_ff   <= pend_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ----------------------------------------------------------- assertions
   `CDQ_ASSERT(a_count_range, count_ff <= CNT_W'(MAX_DEPTH), "count above depth")
   `CDQ_ASSERT(a_count_cells, $countones(valid_vec) == int'(count_ff),
      "occupied cells disagree with count")
   `CDQ_ASSERT(a_rear_onehot, $onehot0(rear_hit), "more than one rear cell")
   `CDQ_ASSERT(a_stall_hold, pend_ff && rsp_valid_ff && !rsp_ready |-> !req_ready,
      "req taken while response path is stalled")
   `CDQ_ASSERT(a_refused_push,
      req_fire && full && (req_data.cmd == CMD_PUSH_FRONT || req_data.cmd == CMD_PUSH_REAR)
      |=> $stable(count_ff), "refused push changed the count")

endmodule

`default_nettype wire
